/* src/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types, constants and the hash micro-op table for the linear probe
// hash table core.
// ----------------------------------------------------------------------------
package lpht_pkg;

    // Table geometry and field widths
    localparam int MAX_SLOTS  = 4096;
    localparam int SLOT_W     = 12;
    localparam int CNT_W      = 13;
    localparam int KEY_W      = 64;
    localparam int VAL_W      = 64;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int MIX_STEPS  = 9;
    localparam int MIX_STEP_W = 4;
    localparam int BIT_IDX_W  = $clog2(KEY_W);
    localparam int SHAMT_W    = 5;

    localparam logic [KEY_W-1:0] EMPTY_KEY      = '1;
    localparam logic [CNT_W-1:0] COUNT_MAX      = '1;
    localparam logic [CFG_W-1:0] SLOTS_CAP      = CFG_W'(MAX_SLOTS);
    localparam logic [CFG_W-1:0] SLOTS_RESET    = 13'd3079;
    localparam logic [CFG_W-1:0] LIMIT_RESET    = 13'd2463;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SLOTS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_LIMIT  = 1'd1;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_INSERTED  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic              cmd;
        logic [KEY_W-1:0]  search_key;
        logic [VAL_W-1:0]  put_value;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot_index;
        logic [VAL_W-1:0]  stored_value;
        logic [CNT_W-1:0]  occupied;
        logic              over_limit;
    } t_rsp;

    typedef enum logic [1:0] {
        H_IDLE,
        H_MIX,
        H_MOD
    } t_hash_state;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_FINISH
    } t_core_state;

    // Left operand of the shared shift-add/xor unit
    typedef enum logic [1:0] {
        SRC_NOT_K,
        SRC_K,
        SRC_ACC
    } t_mix_src;

    typedef struct packed {
        t_mix_src           src;
        logic               use_xor;
        logic               shift_right;
        logic [SHAMT_W-1:0] amount;
        logic               keep_k;
    } t_mix_op;

    // One micro-op per mix step; three-term sums take two steps via acc
    function automatic t_mix_op mix_op(input logic [MIX_STEP_W-1:0] step);
        t_mix_op op;
        case (step)
            4'd0:    op = '{SRC_NOT_K, 1'b0, 1'b0, 5'd21, 1'b0};
            4'd1:    op = '{SRC_K,     1'b1, 1'b1, 5'd24, 1'b0};
            4'd2:    op = '{SRC_K,     1'b0, 1'b0, 5'd3,  1'b1};
            4'd3:    op = '{SRC_ACC,   1'b0, 1'b0, 5'd8,  1'b0};
            4'd4:    op = '{SRC_K,     1'b1, 1'b1, 5'd14, 1'b0};
            4'd5:    op = '{SRC_K,     1'b0, 1'b0, 5'd2,  1'b1};
            4'd6:    op = '{SRC_ACC,   1'b0, 1'b0, 5'd4,  1'b0};
            4'd7:    op = '{SRC_K,     1'b1, 1'b1, 5'd28, 1'b0};
            4'd8:    op = '{SRC_K,     1'b0, 1'b0, 5'd31, 1'b0};
            default: op = '{SRC_K,     1'b0, 1'b0, 5'd0,  1'b1};
        endcase
        return op;
    endfunction

endpackage

/* src/lpht_req_if.sv */
// ----------------------------------------------------------------------------
// lpht_req_if
// Request channel: valid/ready handshake carrying one get or put beat.
// ----------------------------------------------------------------------------
interface lpht_req_if;
    import lpht_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/lpht_rsp_if.sv */
// ----------------------------------------------------------------------------
// lpht_rsp_if
// Response channel: valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
interface lpht_rsp_if;
    import lpht_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/lpht_ram.sv */
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lpht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/lpht_hash.sv */
// ----------------------------------------------------------------------------
// lpht_hash
// Home slot unit: 64-bit shift-add mix on one shared shifter/adder, then
// a restoring remainder by the slot count, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lpht_hash (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lpht_pkg::KEY_W-1:0]  i_key,
    input  logic [lpht_pkg::CFG_W-1:0]  i_slots,
    output logic                        o_done,
    output logic [lpht_pkg::SLOT_W-1:0] o_home
);
    import lpht_pkg::*;

    t_hash_state           r_state;
    t_hash_state           n_state;
    logic [MIX_STEP_W-1:0] r_step;
    logic [BIT_IDX_W-1:0]  r_bit;
    logic [KEY_W-1:0]      r_k;
    logic [KEY_W-1:0]      r_acc;
    logic [CFG_W-1:0]      r_slots;
    logic [SLOT_W-1:0]     r_rem;

    t_mix_op               w_op;
    logic [KEY_W-1:0]      w_opa;
    logic [KEY_W-1:0]      w_shifted;
    logic [KEY_W-1:0]      w_res;
    logic [CFG_W-1:0]      w_trial;
    logic [CFG_W-1:0]      w_diff;
    logic [SLOT_W-1:0]     w_rem_next;

    // Shared shift-add/xor unit
    always_comb begin
        w_op = mix_op(r_step);
        case (w_op.src)
            SRC_NOT_K: w_opa = ~r_k;
            SRC_K:     w_opa = r_k;
            SRC_ACC:   w_opa = r_acc;
            default:   w_opa = r_k;
        endcase
        w_shifted = w_op.shift_right ? (r_k >> w_op.amount) : (r_k << w_op.amount);
        w_res     = w_op.use_xor ? (w_opa ^ w_shifted) : (w_opa + w_shifted);
    end

    // Restoring remainder step
    always_comb begin
        w_trial = {r_rem, r_k[r_bit]};
        w_diff  = w_trial - r_slots;
        if (w_trial >= r_slots) begin
            w_rem_next = w_diff[SLOT_W-1:0];
        end else begin
            w_rem_next = w_trial[SLOT_W-1:0];
        end
    end

    // Sequencer next state and outputs
    always_comb begin
        n_state = r_state;
        o_done  = 1'b0;
        o_home  = w_rem_next;
        case (r_state)
            H_IDLE: begin
                if (i_start) begin
                    n_state = H_MIX;
                end
            end
            H_MIX: begin
                if (r_step == MIX_STEP_W'(MIX_STEPS - 1)) begin
                    n_state = H_MOD;
                end
            end
            H_MOD: begin
                if (r_bit == '0) begin
                    o_done  = 1'b1;
                    n_state = H_IDLE;
                end
            end
            default: n_state = H_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            H_IDLE: begin
                if (i_start) begin
                    r_k     <= i_key;
                    r_slots <= i_slots;
                    r_step  <= '0;
                end
            end
            H_MIX: begin
                r_acc  <= w_res;
                if (!w_op.keep_k) begin
                    r_k <= w_res;
                end
                r_step <= r_step + MIX_STEP_W'(1);
                r_bit  <= '1;
                r_rem  <= '0;
            end
            H_MOD: begin
                r_rem <= w_rem_next;
                r_bit <= r_bit - BIT_IDX_W'(1);
            end
            default: ;
        endcase
    end
endmodule

/* src/linear_probe_hash_table_core.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressed 64-bit key/value table with linear probing: get and put.
//
//   channel   dir  handshake            beat
//   i_req     in   valid/ready          cmd, search_key, put_value
//   o_rsp     out  valid/ready          status, slot_index, stored_value,
//                                       occupied, over_limit
//   i_cfg_*   in   write enable only    register index, 13-bit data
//
// One item at a time. After the accept come the mix steps, the remainder,
// a key store read and a compare for each probed slot, then the commit;
// a reserved key goes straight from the accept to the commit.
// After reset a clearing pass marks every key slot empty; no
// request is taken meanwhile, configuration writes are.
// A stalled response holds in its register; the commit of the next item
// waits for it, and the request side is not ready until that commit is done.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lpht_req_if.sink                       i_req,
    lpht_rsp_if.source                     o_rsp,
    input  logic                           i_cfg_we,
    input  logic [lpht_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lpht_pkg::CFG_W-1:0]     i_cfg_data
);
    import lpht_pkg::*;

    t_core_state       r_state;
    t_core_state       n_state;
    logic [CFG_W-1:0]  r_table_slots;
    logic [CFG_W-1:0]  r_load_limit;
    logic [CFG_W-1:0]  r_slots;
    t_req              r_req;
    logic [SLOT_W-1:0] r_pos;
    logic [CFG_W-1:0]  r_steps;
    logic [SLOT_W-1:0] r_clr_addr;
    t_status           r_status;
    logic [SLOT_W-1:0] r_where;
    logic [VAL_W-1:0]  r_held;
    logic              r_wr_key;
    logic              r_wr_val;
    logic [CNT_W-1:0]  r_count;
    logic              r_out_valid;
    t_rsp              r_rsp;

    logic [CFG_W-1:0]  w_active;
    logic              w_accept;
    logic              w_reserved;
    logic              w_hash_done;
    logic [SLOT_W-1:0] w_home;
    logic [KEY_W-1:0]  w_key_rd;
    logic [VAL_W-1:0]  w_val_rd;
    logic              w_key_we;
    logic [SLOT_W-1:0] w_key_waddr;
    logic [KEY_W-1:0]  w_key_wdata;
    logic              w_val_we;
    logic [CFG_W-1:0]  w_steps_next;
    logic [CFG_W-1:0]  w_pos_inc;
    logic              w_lap_end;
    logic              w_fin_fire;
    logic [CNT_W-1:0]  w_count_next;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_slots <= SLOTS_RESET;
            r_load_limit  <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TABLE_SLOTS: r_table_slots <= i_cfg_data;
                CFG_LOAD_LIMIT:  r_load_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Slot count clamped to 1..MAX_SLOTS
    always_comb begin
        if (r_table_slots == '0) begin
            w_active = CFG_W'(1);
        end else if (r_table_slots > SLOTS_CAP) begin
            w_active = SLOTS_CAP;
        end else begin
            w_active = r_table_slots;
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && (r_state == S_IDLE);
    assign w_reserved  = (i_req.data.search_key == EMPTY_KEY);

    lpht_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && !w_reserved),
        .i_key   (i_req.data.search_key),
        .i_slots (w_active),
        .o_done  (w_hash_done),
        .o_home  (w_home)
    );

    // Key and value stores
    assign w_key_we    = (r_state == S_CLEAR) || (w_fin_fire && r_wr_key);
    assign w_key_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_pos;
    assign w_key_wdata = (r_state == S_CLEAR) ? EMPTY_KEY : r_req.search_key;
    assign w_val_we    = w_fin_fire && r_wr_val;

    lpht_ram #(.WIDTH(KEY_W), .DEPTH(MAX_SLOTS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (w_key_waddr),
        .i_wdata (w_key_wdata),
        .i_raddr (r_pos),
        .o_rdata (w_key_rd)
    );

    lpht_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SLOTS)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_val_we),
        .i_waddr (r_pos),
        .i_wdata (r_req.put_value),
        .i_raddr (r_pos),
        .o_rdata (w_val_rd)
    );

    // Probe walk helpers
    assign w_steps_next = r_steps + CFG_W'(1);
    assign w_lap_end    = (w_steps_next == r_slots);
    assign w_pos_inc    = {1'b0, r_pos} + CFG_W'(1);
    assign w_fin_fire   = (r_state == S_FINISH) && (!r_out_valid || o_rsp.ready);
    assign w_count_next = (r_wr_key && (r_count != COUNT_MAX)) ?
                          (r_count + CNT_W'(1)) : r_count;

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = w_reserved ? S_FINISH : S_HASH;
                end
            end
            S_HASH: begin
                if (w_hash_done) begin
                    n_state = S_READ;
                end
            end
            S_READ:  n_state = S_CHECK;
            S_CHECK: begin
                if ((w_key_rd == r_req.search_key) || (w_key_rd == EMPTY_KEY) || w_lap_end) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_READ;
                end
            end
            S_FINISH: begin
                if (w_fin_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + SLOT_W'(1);
            end
        end
    end

    // Request datapath: latch, probe, decide
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_req    <= i_req.data;
                    r_slots  <= w_active;
                    r_status <= ST_NOT_FOUND;
                    r_where  <= '0;
                    r_held   <= '0;
                    r_wr_key <= 1'b0;
                    r_wr_val <= 1'b0;
                end
            end
            S_HASH: begin
                r_pos   <= w_home;
                r_steps <= '0;
            end
            S_CHECK: begin
                if (w_key_rd == r_req.search_key) begin
                    // hit: put overwrites the value
                    r_status <= ST_FOUND;
                    r_where  <= r_pos;
                    r_held   <= r_req.cmd ? r_req.put_value : w_val_rd;
                    r_wr_val <= r_req.cmd;
                end else if (w_key_rd == EMPTY_KEY) begin
                    // empty slot: put claims it, get misses
                    if (r_req.cmd) begin
                        r_status <= ST_INSERTED;
                        r_where  <= r_pos;
                        r_held   <= r_req.put_value;
                        r_wr_key <= 1'b1;
                        r_wr_val <= 1'b1;
                    end
                end else if (w_lap_end) begin
                    // full lap without a free slot
                    r_status <= r_req.cmd ? ST_FULL : ST_NOT_FOUND;
                end else begin
                    r_pos   <= (w_pos_inc >= r_slots) ? '0 : w_pos_inc[SLOT_W-1:0];
                    r_steps <= w_steps_next;
                end
            end
            default: ;
        endcase
    end

    // Occupancy count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_fin_fire) begin
            r_count <= w_count_next;
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_fire) begin
            r_rsp.status       <= r_status;
            r_rsp.slot_index   <= r_where;
            r_rsp.stored_value <= r_held;
            r_rsp.occupied     <= w_count_next;
            r_rsp.over_limit   <= (w_count_next >= r_load_limit);
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

    // Checks
    a_count_only_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_FINISH) |=> $stable(r_count))
        else $error("occupancy changed outside commit");

    a_insert_bumps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin_fire && r_wr_key) |=>
        ((r_count == $past(r_count) + CNT_W'(1)) || ($past(r_count) == COUNT_MAX)))
        else $error("insert did not bump occupancy");

    a_rsp_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FINISH))
        else $error("response raised without commit");

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (({1'b0, r_pos} < r_slots) && (r_steps < r_slots)))
        else $error("probe left the active slot range");

    a_hash_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hash_done |-> (r_state == S_HASH))
        else $error("hash finished while not awaited");
endmodule
